// ----- src/lfuc_pkg.sv -----
// ============================================================================
// lfuc_pkg
// Shared widths, reset values and operation codes for the LFU cache with
// least-recently-used tie break.
// ============================================================================
package lfuc_pkg;

   localparam int KEY_BITS           = 32;
   localparam int VALUE_BITS         = 32;
   localparam int CAP_REG_BITS       = 5;
   localparam int DEFAULT_CAPACITY   = 16;
   localparam int DEFAULT_COUNT_BITS = 16;

   localparam logic [CAP_REG_BITS-1:0] CAP_RESET = 5'd16;

   localparam logic ACTION_GET = 1'b0;
   localparam logic ACTION_PUT = 1'b1;

endpackage

// ----- src/lfuc_entry_ram.sv -----
// ============================================================================
// lfuc_entry_ram
// Entry store of the cache: one write port and one read port with a
// registered read.
// ============================================================================
module lfuc_entry_ram #(
   parameter int DEPTH     = 16,
   parameter int WIDTH     = 84,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/lfuc_ctrl.sv -----
// ============================================================================
// lfuc_ctrl
// Access sequencer: sweeps the entry store to find the key, a free slot and
// the eviction victim, then, on a hit or an insert, sweeps it again to age
// the recency ranks and write the touched or inserted entry.
// ============================================================================
module lfuc_ctrl #(
   parameter int CAPACITY   = 16,
   parameter int COUNT_BITS = 16,
   parameter int IDX_BITS   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   parameter int ENTRY_BITS = lfuc_pkg::KEY_BITS + lfuc_pkg::VALUE_BITS + COUNT_BITS + IDX_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_action,
   input  logic [lfuc_pkg::KEY_BITS-1:0]     req_lookup_key,
   input  logic [lfuc_pkg::VALUE_BITS-1:0]   req_store_value,
   input  logic [lfuc_pkg::CAP_REG_BITS-1:0] cap_reg,
   output logic                              rsp_strobe,
   output logic                              rsp_hit,
   output logic [lfuc_pkg::VALUE_BITS-1:0]   rsp_read_value,
   output logic                              rsp_evicted,
   output logic [lfuc_pkg::KEY_BITS-1:0]     rsp_evicted_key,
   output logic                              ram_rd_en,
   output logic [IDX_BITS-1:0]               ram_rd_addr,
   input  logic [ENTRY_BITS-1:0]             ram_rd_data,
   output logic                              ram_wr_en,
   output logic [IDX_BITS-1:0]               ram_wr_addr,
   output logic [ENTRY_BITS-1:0]             ram_wr_data
);

   import lfuc_pkg::*;

   localparam int RANK_BITS = IDX_BITS;
   localparam int CNT_BITS  = $clog2(CAPACITY + 1);
   localparam int CMP_BITS  = (CNT_BITS > CAP_REG_BITS) ? CNT_BITS : CAP_REG_BITS;
   localparam int COUNT_LSB = RANK_BITS;
   localparam int VALUE_LSB = RANK_BITS + COUNT_BITS;
   localparam int KEY_LSB   = RANK_BITS + COUNT_BITS + VALUE_BITS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_UPDATE
   } state_type;

   typedef enum logic [1:0] {
      UPD_HIT,
      UPD_EVICT,
      UPD_ALL
   } upd_mode_type;

   state_type               state_ff, state_in;
   upd_mode_type            mode_ff, mode_in;
   logic [CNT_BITS-1:0]     ptr_ff, ptr_in;
   logic                    chk_en_ff, chk_en_in;
   logic [IDX_BITS-1:0]     chk_idx_ff, chk_idx_in;
   logic                    action_ff, action_in;
   logic [KEY_BITS-1:0]     key_ff, key_in;
   logic [VALUE_BITS-1:0]   value_ff, value_in;
   logic                    hit_found_ff, hit_found_in;
   logic [IDX_BITS-1:0]     hit_idx_ff, hit_idx_in;
   logic [RANK_BITS-1:0]    hit_rank_ff, hit_rank_in;
   logic [COUNT_BITS-1:0]   hit_count_ff, hit_count_in;
   logic [VALUE_BITS-1:0]   hit_value_ff, hit_value_in;
   logic                    free_found_ff, free_found_in;
   logic [IDX_BITS-1:0]     free_idx_ff, free_idx_in;
   logic                    vic_found_ff, vic_found_in;
   logic [IDX_BITS-1:0]     vic_idx_ff, vic_idx_in;
   logic [COUNT_BITS-1:0]   vic_count_ff, vic_count_in;
   logic [RANK_BITS-1:0]    vic_rank_ff, vic_rank_in;
   logic [KEY_BITS-1:0]     vic_key_ff, vic_key_in;
   logic [IDX_BITS-1:0]     tgt_idx_ff, tgt_idx_in;
   logic [ENTRY_BITS-1:0]   tgt_entry_ff, tgt_entry_in;
   logic [RANK_BITS-1:0]    thr_ff, thr_in;
   logic [CAPACITY-1:0]     valid_ff, valid_in;
   logic [CNT_BITS-1:0]     occ_ff, occ_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;
   logic                    rsp_hit_ff, rsp_hit_in;
   logic [VALUE_BITS-1:0]   rsp_read_value_ff, rsp_read_value_in;
   logic                    rsp_evicted_ff, rsp_evicted_in;
   logic [KEY_BITS-1:0]     rsp_evicted_key_ff, rsp_evicted_key_in;

   logic [CMP_BITS-1:0]     cap_wide;
   logic [CNT_BITS-1:0]     cap_limit;
   logic                    cap_zero;
   logic                    ptr_done;
   logic                    cur_valid;
   logic [KEY_BITS-1:0]     rd_key;
   logic [VALUE_BITS-1:0]   rd_value;
   logic [COUNT_BITS-1:0]   rd_count;
   logic [RANK_BITS-1:0]    rd_rank;
   logic                    rank_inc;
   logic [COUNT_BITS-1:0]   hit_count_next;
   logic [VALUE_BITS-1:0]   hit_store;

   assign cap_wide  = CMP_BITS'(cap_reg);
   assign cap_limit = (cap_wide > CMP_BITS'(CAPACITY)) ? CNT_BITS'(CAPACITY)
                                                      : CNT_BITS'(cap_wide);
   assign cap_zero  = (cap_reg == '0);
   assign ptr_done  = (ptr_ff == CNT_BITS'(CAPACITY));
   assign cur_valid = valid_ff[chk_idx_ff];

   assign rd_key   = ram_rd_data[KEY_LSB +: KEY_BITS];
   assign rd_value = ram_rd_data[VALUE_LSB +: VALUE_BITS];
   assign rd_count = ram_rd_data[COUNT_LSB +: COUNT_BITS];
   assign rd_rank  = ram_rd_data[RANK_BITS-1:0];

   assign hit_count_next = (hit_count_ff == {COUNT_BITS{1'b1}}) ? hit_count_ff
                                                                : hit_count_ff + COUNT_BITS'(1);
   assign hit_store      = (action_ff == ACTION_PUT) ? value_ff : hit_value_ff;

   always_comb begin
      unique case (mode_ff)
         UPD_HIT:   rank_inc = (rd_rank < thr_ff);
         UPD_EVICT: rank_inc = (rd_rank <= thr_ff);
         UPD_ALL:   rank_inc = 1'b1;
         default:   rank_inc = 1'b0;
      endcase
   end

   always_comb begin
      state_in           = state_ff;
      mode_in            = mode_ff;
      ptr_in             = ptr_ff;
      chk_en_in          = 1'b0;
      chk_idx_in         = ptr_ff[IDX_BITS-1:0];
      action_in          = action_ff;
      key_in             = key_ff;
      value_in           = value_ff;
      hit_found_in       = hit_found_ff;
      hit_idx_in         = hit_idx_ff;
      hit_rank_in        = hit_rank_ff;
      hit_count_in       = hit_count_ff;
      hit_value_in       = hit_value_ff;
      free_found_in      = free_found_ff;
      free_idx_in        = free_idx_ff;
      vic_found_in       = vic_found_ff;
      vic_idx_in         = vic_idx_ff;
      vic_count_in       = vic_count_ff;
      vic_rank_in        = vic_rank_ff;
      vic_key_in         = vic_key_ff;
      tgt_idx_in         = tgt_idx_ff;
      tgt_entry_in       = tgt_entry_ff;
      thr_in             = thr_ff;
      valid_in           = valid_ff;
      occ_in             = occ_ff;
      rsp_strobe_in      = 1'b0;
      rsp_hit_in         = rsp_hit_ff;
      rsp_read_value_in  = rsp_read_value_ff;
      rsp_evicted_in     = rsp_evicted_ff;
      rsp_evicted_key_in = rsp_evicted_key_ff;
      ram_rd_en          = 1'b0;
      ram_rd_addr        = ptr_ff[IDX_BITS-1:0];
      ram_wr_en          = 1'b0;
      ram_wr_addr        = chk_idx_ff;
      ram_wr_data        = ram_rd_data;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               action_in          = req_action;
               key_in             = req_lookup_key;
               value_in           = req_store_value;
               hit_found_in       = 1'b0;
               free_found_in      = 1'b0;
               vic_found_in       = 1'b0;
               ptr_in             = '0;
               rsp_hit_in         = 1'b0;
               rsp_read_value_in  = '0;
               rsp_evicted_in     = 1'b0;
               rsp_evicted_key_in = '0;
               if (cap_zero) begin
                  rsp_strobe_in = 1'b1;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            if (!ptr_done) begin
               ram_rd_en = 1'b1;
               chk_en_in = 1'b1;
               ptr_in    = ptr_ff + CNT_BITS'(1);
            end
            if (chk_en_ff) begin
               if (cur_valid) begin
                  if (rd_key == key_ff && !hit_found_ff) begin
                     hit_found_in = 1'b1;
                     hit_idx_in   = chk_idx_ff;
                     hit_rank_in  = rd_rank;
                     hit_count_in = rd_count;
                     hit_value_in = rd_value;
                  end
                  if (!vic_found_ff || rd_count < vic_count_ff ||
                      (rd_count == vic_count_ff && rd_rank > vic_rank_ff)) begin
                     vic_found_in = 1'b1;
                     vic_idx_in   = chk_idx_ff;
                     vic_count_in = rd_count;
                     vic_rank_in  = rd_rank;
                     vic_key_in   = rd_key;
                  end
               end else if (!free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = chk_idx_ff;
               end
            end
            if (ptr_done) begin
               state_in = ST_DECIDE;
            end
         end

         ST_DECIDE: begin
            ptr_in = '0;
            priority if (hit_found_ff) begin
               rsp_hit_in        = 1'b1;
               rsp_read_value_in = (action_ff == ACTION_GET) ? hit_value_ff : '0;
               tgt_idx_in        = hit_idx_ff;
               tgt_entry_in      = {key_ff, hit_store, hit_count_next, RANK_BITS'(0)};
               thr_in            = hit_rank_ff;
               mode_in           = UPD_HIT;
               state_in          = ST_UPDATE;
            end else if (action_ff == ACTION_PUT && occ_ff < cap_limit && free_found_ff) begin
               tgt_idx_in           = free_idx_ff;
               tgt_entry_in         = {key_ff, value_ff, COUNT_BITS'(1), RANK_BITS'(0)};
               mode_in              = UPD_ALL;
               valid_in[free_idx_ff] = 1'b1;
               occ_in               = occ_ff + CNT_BITS'(1);
               state_in             = ST_UPDATE;
            end else if (action_ff == ACTION_PUT && vic_found_ff) begin
               rsp_evicted_in     = 1'b1;
               rsp_evicted_key_in = vic_key_ff;
               tgt_idx_in         = vic_idx_ff;
               tgt_entry_in       = {key_ff, value_ff, COUNT_BITS'(1), RANK_BITS'(0)};
               thr_in             = vic_rank_ff;
               mode_in            = UPD_EVICT;
               state_in           = ST_UPDATE;
            end else begin
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         ST_UPDATE: begin
            if (!ptr_done) begin
               ram_rd_en = 1'b1;
               chk_en_in = 1'b1;
               ptr_in    = ptr_ff + CNT_BITS'(1);
            end
            if (chk_en_ff) begin
               if (chk_idx_ff == tgt_idx_ff) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = tgt_entry_ff;
               end else if (cur_valid) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = {ram_rd_data[ENTRY_BITS-1:RANK_BITS],
                                 rd_rank + RANK_BITS'(rank_inc)};
               end
            end
            if (ptr_done) begin
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         mode_ff            <= UPD_ALL;
         ptr_ff             <= '0;
         chk_en_ff          <= 1'b0;
         chk_idx_ff         <= '0;
         action_ff          <= ACTION_GET;
         key_ff             <= '0;
         value_ff           <= '0;
         hit_found_ff       <= 1'b0;
         hit_idx_ff         <= '0;
         hit_rank_ff        <= '0;
         hit_count_ff       <= '0;
         hit_value_ff       <= '0;
         free_found_ff      <= 1'b0;
         free_idx_ff        <= '0;
         vic_found_ff       <= 1'b0;
         vic_idx_ff         <= '0;
         vic_count_ff       <= '0;
         vic_rank_ff        <= '0;
         vic_key_ff         <= '0;
         tgt_idx_ff         <= '0;
         tgt_entry_ff       <= '0;
         thr_ff             <= '0;
         valid_ff           <= '0;
         occ_ff             <= '0;
         rsp_strobe_ff      <= 1'b0;
         rsp_hit_ff         <= 1'b0;
         rsp_read_value_ff  <= '0;
         rsp_evicted_ff     <= 1'b0;
         rsp_evicted_key_ff <= '0;
      end else begin
         state_ff           <= state_in;
         mode_ff            <= mode_in;
         ptr_ff             <= ptr_in;
         chk_en_ff          <= chk_en_in;
         chk_idx_ff         <= chk_idx_in;
         action_ff          <= action_in;
         key_ff             <= key_in;
         value_ff           <= value_in;
         hit_found_ff       <= hit_found_in;
         hit_idx_ff         <= hit_idx_in;
         hit_rank_ff        <= hit_rank_in;
         hit_count_ff       <= hit_count_in;
         hit_value_ff       <= hit_value_in;
         free_found_ff      <= free_found_in;
         free_idx_ff        <= free_idx_in;
         vic_found_ff       <= vic_found_in;
         vic_idx_ff         <= vic_idx_in;
         vic_count_ff       <= vic_count_in;
         vic_rank_ff        <= vic_rank_in;
         vic_key_ff         <= vic_key_in;
         tgt_idx_ff         <= tgt_idx_in;
         tgt_entry_ff       <= tgt_entry_in;
         thr_ff             <= thr_in;
         valid_ff           <= valid_in;
         occ_ff             <= occ_in;
         rsp_strobe_ff      <= rsp_strobe_in;
         rsp_hit_ff         <= rsp_hit_in;
         rsp_read_value_ff  <= rsp_read_value_in;
         rsp_evicted_ff     <= rsp_evicted_in;
         rsp_evicted_key_ff <= rsp_evicted_key_in;
      end
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_evicted     = rsp_evicted_ff;
   assign rsp_evicted_key = rsp_evicted_key_ff;

endmodule

// ----- src/lfu_cache_lru_tiebreak.sv -----
// ============================================================================
// lfu_cache_lru_tiebreak
// Fully associative key/value cache, least frequently used replacement with
// the least recently used entry chosen among equal use counts.
// ============================================================================
// An item is taken when start is high and busy is low; its result appears on
// the rsp_ ports for one cycle under rsp_strobe and must be taken then, as the
// block cannot hold it. Entries live in a single memory with one read and one
// write port, and each item sweeps it one entry per cycle: a lookup pass,
// then, for accesses that change state, an update pass. Busy stays high
// until the last pass has ended, so no new item is taken while one is in
// progress. While the capacity register is zero an item is answered without
// any pass. The capacity register may only be written while busy is low.
// ============================================================================
module lfu_cache_lru_tiebreak #(
   parameter int CAPACITY   = lfuc_pkg::DEFAULT_CAPACITY,
   parameter int COUNT_BITS = lfuc_pkg::DEFAULT_COUNT_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_action,
   input  logic [lfuc_pkg::KEY_BITS-1:0]     req_lookup_key,
   input  logic [lfuc_pkg::VALUE_BITS-1:0]   req_store_value,
   output logic                              rsp_strobe,
   output logic                              rsp_hit,
   output logic [lfuc_pkg::VALUE_BITS-1:0]   rsp_read_value,
   output logic                              rsp_evicted,
   output logic [lfuc_pkg::KEY_BITS-1:0]     rsp_evicted_key,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lfuc_pkg::CAP_REG_BITS-1:0] csr_capacity_in_use
);

   import lfuc_pkg::*;

   localparam int IDX_BITS   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int ENTRY_BITS = KEY_BITS + VALUE_BITS + COUNT_BITS + IDX_BITS;

   logic [CAP_REG_BITS-1:0] cap_ff;
   logic [CAP_REG_BITS-1:0] cap_in;
   logic                    ram_rd_en;
   logic [IDX_BITS-1:0]     ram_rd_addr;
   logic [ENTRY_BITS-1:0]   ram_rd_data;
   logic                    ram_wr_en;
   logic [IDX_BITS-1:0]     ram_wr_addr;
   logic [ENTRY_BITS-1:0]   ram_wr_data;

   assign csr_ready = 1'b1;
   assign cap_in    = (csr_valid && csr_ready) ? csr_capacity_in_use : cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   lfuc_ctrl #(
      .CAPACITY   (CAPACITY),
      .COUNT_BITS (COUNT_BITS),
      .IDX_BITS   (IDX_BITS),
      .ENTRY_BITS (ENTRY_BITS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_lookup_key  (req_lookup_key),
      .req_store_value (req_store_value),
      .cap_reg         (cap_ff),
      .rsp_strobe      (rsp_strobe),
      .rsp_hit         (rsp_hit),
      .rsp_read_value  (rsp_read_value),
      .rsp_evicted     (rsp_evicted),
      .rsp_evicted_key (rsp_evicted_key),
      .ram_rd_en       (ram_rd_en),
      .ram_rd_addr     (ram_rd_addr),
      .ram_rd_data     (ram_rd_data),
      .ram_wr_en       (ram_wr_en),
      .ram_wr_addr     (ram_wr_addr),
      .ram_wr_data     (ram_wr_data)
   );

   lfuc_entry_ram #(
      .DEPTH     (CAPACITY),
      .WIDTH     (ENTRY_BITS),
      .ADDR_BITS (IDX_BITS)
   ) u_entry_ram (
      .clock   (clock),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data)
   );

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the LFU key/value cache with least-recently-used
// tie break. A queue of pending items (accesses, capacity writes and drain
// points) feeds a clocked driver that issues them in random bursts. Every
// accepted access is run through a cycle-free cache predictor, and a clocked
// monitor compares each strobed result, field by field, with the oldest
// prediction. The use counter is built narrow so that saturation is reached.
// ============================================================================
module testbench;
   import lfuc_pkg::*;

   localparam int CAPACITY       = DEFAULT_CAPACITY;
   localparam int USE_COUNT_BITS = 4;
   localparam int RANK_BITS      = $clog2(CAPACITY);
   localparam int CLOCK_PERIOD   = 12;
   localparam int SETTLE_CYCLES  = 2 * CAPACITY + 8;
   localparam int TIMEOUT_CYCLES = 500000;
   localparam logic [USE_COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef enum logic [1:0] {OP_ACCESS, OP_CONFIG, OP_DRAIN} pending_kind_type;

   typedef struct {
      pending_kind_type        kind;
      logic                    action;
      logic [KEY_BITS-1:0]     key;
      logic [VALUE_BITS-1:0]   value;
      logic [CAP_REG_BITS-1:0] capacity;
   } pending_op_type;

   typedef struct packed {
      logic                  hit;
      logic [VALUE_BITS-1:0] read_value;
      logic                  evicted;
      logic [KEY_BITS-1:0]   evicted_key;
   } cache_reply_type;

   logic                    clock               = 1'b0;
   logic                    reset               = 1'b1;
   logic                    start               = 1'b0;
   logic                    busy;
   logic                    req_action          = ACTION_GET;
   logic [KEY_BITS-1:0]     req_lookup_key      = '0;
   logic [VALUE_BITS-1:0]   req_store_value     = '0;
   logic                    rsp_strobe;
   logic                    rsp_hit;
   logic [VALUE_BITS-1:0]   rsp_read_value;
   logic                    rsp_evicted;
   logic [KEY_BITS-1:0]     rsp_evicted_key;
   logic                    csr_valid           = 1'b0;
   logic                    csr_ready;
   logic [CAP_REG_BITS-1:0] csr_capacity_in_use = CAP_RESET;

   pending_op_type  op_queue[$];
   cache_reply_type pending_replies[$];
   int              mismatch_count = 0;
   int              burst_left     = 1;
   int              gap_left       = 0;
   int              quiet_cycles   = 0;

   logic                      line_valid [CAPACITY];
   logic [KEY_BITS-1:0]       line_key   [CAPACITY];
   logic [VALUE_BITS-1:0]     line_value [CAPACITY];
   logic [USE_COUNT_BITS-1:0] line_count [CAPACITY];
   logic [RANK_BITS-1:0]      line_rank  [CAPACITY];
   int                        occupancy;
   logic [CAP_REG_BITS-1:0]   capacity_reg;

   lfu_cache_lru_tiebreak #(
      .CAPACITY   (CAPACITY),
      .COUNT_BITS (USE_COUNT_BITS)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_action          (req_action),
      .req_lookup_key      (req_lookup_key),
      .req_store_value     (req_store_value),
      .rsp_strobe          (rsp_strobe),
      .rsp_hit             (rsp_hit),
      .rsp_read_value      (rsp_read_value),
      .rsp_evicted         (rsp_evicted),
      .rsp_evicted_key     (rsp_evicted_key),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_capacity_in_use (csr_capacity_in_use)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic cache_reply_type lfu_access(input logic op,
                                                  input logic [KEY_BITS-1:0] k,
                                                  input logic [VALUE_BITS-1:0] v);
      cache_reply_type      res;
      int                   eff_cap;
      int                   found;
      int                   slot;
      int                   i;
      logic [RANK_BITS-1:0] old_rank;
      res     = '0;
      eff_cap = (capacity_reg > CAPACITY) ? CAPACITY : int'(capacity_reg);
      found   = -1;
      slot    = -1;
      if (eff_cap != 0) begin
         for (i = 0; i < CAPACITY; i++) begin
            if (found < 0 && line_valid[i] && line_key[i] == k) found = i;
         end
         if (found >= 0) begin
            res.hit  = 1'b1;
            old_rank = line_rank[found];
            for (i = 0; i < CAPACITY; i++) begin
               if (line_valid[i] && i != found && line_rank[i] < old_rank) line_rank[i]++;
            end
            line_rank[found] = '0;
            if (line_count[found] != COUNT_MAX) line_count[found]++;
            if (op == ACTION_GET) res.read_value = line_value[found];
            else line_value[found] = v;
         end else if (op == ACTION_PUT) begin
            if (occupancy < eff_cap) begin
               for (i = 0; i < CAPACITY; i++) begin
                  if (slot < 0 && !line_valid[i]) slot = i;
               end
            end
            if (slot < 0) begin
               for (i = 0; i < CAPACITY; i++) begin
                  if (line_valid[i] && (slot < 0 || line_count[i] < line_count[slot] ||
                      (line_count[i] == line_count[slot] && line_rank[i] > line_rank[slot])))
                     slot = i;
               end
               if (slot >= 0) begin
                  res.evicted     = 1'b1;
                  res.evicted_key = line_key[slot];
                  line_valid[slot] = 1'b0;
                  old_rank = line_rank[slot];
                  for (i = 0; i < CAPACITY; i++) begin
                     if (line_valid[i] && line_rank[i] > old_rank) line_rank[i]--;
                  end
                  if (occupancy > 0) occupancy--;
               end
            end
            if (slot >= 0) begin
               for (i = 0; i < CAPACITY; i++) begin
                  if (line_valid[i]) line_rank[i]++;
               end
               line_valid[slot] = 1'b1;
               line_key[slot]   = k;
               line_value[slot] = v;
               line_count[slot] = USE_COUNT_BITS'(1);
               line_rank[slot]  = '0;
               occupancy++;
            end
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin : drive_items
      logic           start_n;
      logic           csr_valid_n;
      pending_op_type head;
      start_n     = start;
      csr_valid_n = csr_valid;
      if (reset) begin
         start_n      = 1'b0;
         csr_valid_n  = 1'b0;
         capacity_reg = CAP_RESET;
         occupancy    = 0;
         for (int i = 0; i < CAPACITY; i++) line_valid[i] = 1'b0;
      end else begin
         if (start && !busy) begin
            pending_replies.push_back(lfu_access(req_action, req_lookup_key, req_store_value));
            void'(op_queue.pop_front());
            start_n = 1'b0;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 40)
                                                         : $urandom_range(1, 6);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
            end
         end
         if (csr_valid && csr_ready) begin
            capacity_reg = csr_capacity_in_use;
            void'(op_queue.pop_front());
            csr_valid_n = 1'b0;
         end
         if (!start_n && !csr_valid_n && op_queue.size() > 0) begin
            head = op_queue[0];
            case (head.kind)
               OP_ACCESS: begin
                  if (gap_left > 0) begin
                     gap_left--;
                  end else begin
                     start_n = 1'b1;
                     req_action      <= head.action;
                     req_lookup_key  <= head.key;
                     req_store_value <= head.value;
                  end
               end
               OP_CONFIG: begin
                  if (pending_replies.size() == 0 && quiet_cycles >= SETTLE_CYCLES) begin
                     csr_valid_n = 1'b1;
                     csr_capacity_in_use <= head.capacity;
                  end
               end
               default: begin
                  if (pending_replies.size() == 0) void'(op_queue.pop_front());
               end
            endcase
         end
      end
      if (start_n || csr_valid_n || pending_replies.size() != 0) quiet_cycles = 0;
      else quiet_cycles++;
      start     <= start_n;
      csr_valid <= csr_valid_n;
   end

   always @(posedge clock) begin : check_replies
      cache_reply_type exp;
      if (!reset && rsp_strobe) begin
         if (pending_replies.size() == 0) begin
            $error("result strobed with no item outstanding");
            mismatch_count++;
         end else begin
            exp = pending_replies.pop_front();
            if (rsp_hit !== exp.hit) begin
               $error("hit: expected %0h, got %0h", exp.hit, rsp_hit);
               mismatch_count++;
            end
            if (rsp_read_value !== exp.read_value) begin
               $error("read_value: expected %0h, got %0h", exp.read_value, rsp_read_value);
               mismatch_count++;
            end
            if (rsp_evicted !== exp.evicted) begin
               $error("evicted: expected %0h, got %0h", exp.evicted, rsp_evicted);
               mismatch_count++;
            end
            if (rsp_evicted_key !== exp.evicted_key) begin
               $error("evicted_key: expected %0h, got %0h", exp.evicted_key, rsp_evicted_key);
               mismatch_count++;
            end
         end
      end
   end

   task automatic push_access(input logic op, input logic [KEY_BITS-1:0] k,
                              input logic [VALUE_BITS-1:0] v);
      pending_op_type item;
      item.kind     = OP_ACCESS;
      item.action   = op;
      item.key      = k;
      item.value    = v;
      item.capacity = '0;
      op_queue.push_back(item);
   endtask

   task automatic push_marker(input pending_kind_type kind,
                              input logic [CAP_REG_BITS-1:0] cap);
      pending_op_type item;
      item.kind     = kind;
      item.action   = ACTION_GET;
      item.key      = '0;
      item.value    = '0;
      item.capacity = cap;
      op_queue.push_back(item);
   endtask

   initial begin : stimulus
      logic [KEY_BITS-1:0]     key_pool [32];
      logic [CAP_REG_BITS-1:0] phase_caps [8];
      logic [KEY_BITS-1:0]     k;
      logic [VALUE_BITS-1:0]   v;
      int                      pool_size;
      int                      eff_cap;
      int                      items;
      int                      r;
      phase_caps = '{5'd16, 5'd3, 5'd31, 5'd1, 5'd0, 5'd8, 5'd17, 5'd0};
      phase_caps[7] = 5'($urandom_range(1, 31));
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < 32; i++) key_pool[i] = $urandom;

      push_access(ACTION_GET, '0, '0);
      push_access(ACTION_PUT, '0, '1);
      push_access(ACTION_GET, '0, '0);
      push_access(ACTION_PUT, '1, '0);
      push_access(ACTION_PUT, '0, 32'h1234_5678);
      push_access(ACTION_GET, '1, '0);
      push_access(ACTION_PUT, 32'h5A5A_A5A5, 32'h0000_0001);
      push_access(ACTION_PUT, 32'hA5A5_5A5A, 32'h8000_0000);
      // Capacity drops below occupancy; the two newest single-use entries then go in age order.
      push_marker(OP_CONFIG, 5'd2);
      push_access(ACTION_GET, '0, '0);
      push_access(ACTION_PUT, 32'h8000_0000, 32'h0000_0007);
      push_access(ACTION_PUT, 32'h0000_0001, 32'hFFFF_0000);
      // Touch one entry past the top of its use count.
      repeat (12) push_access(ACTION_GET, '0, '0);
      push_marker(OP_CONFIG, 5'd0);
      push_access(ACTION_PUT, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
      push_access(ACTION_GET, '0, '0);

      foreach (phase_caps[p]) begin
         push_marker(OP_CONFIG, phase_caps[p]);
         eff_cap   = (phase_caps[p] > CAPACITY) ? CAPACITY : int'(phase_caps[p]);
         pool_size = (eff_cap == 0 ? 4 : eff_cap) + $urandom_range(1, 8);
         if (pool_size > 32) pool_size = 32;
         items = (eff_cap == 0) ? 15 : 55;
         for (int n = 0; n < items; n++) begin
            r = $urandom_range(0, 99);
            if (r < 10) k = $urandom;
            else if (r < 45) k = key_pool[$urandom_range(0, 2)];
            else k = key_pool[$urandom_range(0, pool_size - 1)];
            r = $urandom_range(0, 9);
            v = (r == 0) ? '0 : (r == 1) ? '1 : $urandom;
            push_access(1'($urandom_range(0, 1)), k, v);
            if ((p == 0 && n == items / 2) || $urandom_range(0, 99) < 2)
               push_marker(OP_DRAIN, '0);
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (op_queue.size() != 0 || start || csr_valid || pending_replies.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_replies.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
